@@ rtl/core/sgt_pkg.sv @@
// Shared types and constants of the scaled game timebase.
package sgt_pkg;

    // Field widths
    localparam int MODE_W     = 3;
    localparam int TIME_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int STEP_W     = 16;
    localparam int MINF_W     = 10;
    localparam int WAIT_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Output beat: five time words, two flags, the wait, padded to whole bytes
    localparam int OUT_USED_W  = 5 * TIME_W + 2 + WAIT_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Product of a real delta and the Q8.8 scale
    localparam int PROD_W = TIME_W + SCALE_W;
    localparam int FRAC_W = 8;

    // Register reset values and limits
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd256;
    localparam logic [STEP_W-1:0]  STEP_RESET    = 16'd16;
    localparam logic [MINF_W-1:0]  MINF_RESET    = 10'd16;
    localparam logic [MINF_W-1:0]  MINF_MAX      = 10'd1000;
    localparam logic [PROD_W-1:0]  ROUND_HALF    = PROD_W'(128);

    // Command codes carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME_BEGIN = 3'd0,
        MODE_FRAME_END   = 3'd1,
        MODE_START       = 3'd2,
        MODE_STOP        = 3'd3,
        MODE_PAUSE       = 3'd4,
        MODE_RESUME      = 3'd5,
        MODE_STEP        = 3'd6
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_STEP      = 2'd1,
        CFG_LIMIT_EN  = 2'd2,
        CFG_MIN_FRAME = 2'd3
    } t_cfg_idx;

endpackage

@@ rtl/core/scaled_game_timebase_unit.sv @@
// Top level of the scaled game timebase: command pipe, time state and result register.
//
// Commands enter on the s_axis channel: tuser carries the mode, tdata the real
// timer reading in ms. Every accepted beat yields exactly one result beat on
// m_axis, holding the state after the command plus the end-of-frame wait.
// Configuration registers go through i_cfg_we / i_cfg_addr / i_cfg_data, one per clock;
// the user must write them only while no command is in flight; nothing enforces it.
//
// Pipeline: a command is captured in the input register and evaluated from
// there, and its result is registered in the result register. Throughput
// is one command per cycle while the receiver takes results; the path that
// sets the clock is the 32x16 scale multiply followed by the game time add.
//
// When the receiver stalls the result register holds; one further command may
// wait in the input register, after which s_axis_tready drops until the
// result is taken. Synchronous active-low reset clears the time state, the
// run flags and both valid bits and restores the register defaults
// (scale 1.0, step 16 ms, limiting off, minimum frame 16 ms).
module scaled_game_timebase_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sgt_pkg::TIME_W-1:0]     s_axis_tdata,  // [31:0] now_ms
    input  logic [sgt_pkg::MODE_W-1:0]     s_axis_tuser,  // [2:0] mode
    // result channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] game_delta_ms, [63:32] real_delta_ms, [95:64] game_time_ms,
    // [127:96] last_real_ms, [159:128] frames, [160] is_started,
    // [161] is_running, [171:162] wait_ms, [175:172] zero
    output logic [sgt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [sgt_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sgt_pkg::*;

    // configuration
    logic [SCALE_W-1:0] r_scale;
    logic [STEP_W-1:0]  r_step_ms;
    logic               r_limit_en;
    logic [MINF_W-1:0]  r_min_frame;

    // input register
    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [TIME_W-1:0]  r_in_now;

    // time state
    logic [TIME_W-1:0]  r_frames, n_frames;
    logic [TIME_W-1:0]  r_last_real, n_last_real;
    logic [TIME_W-1:0]  r_real_delta, n_real_delta;
    logic [TIME_W-1:0]  r_game_delta, n_game_delta;
    logic [TIME_W-1:0]  r_game_time, n_game_time;
    logic               r_started, n_started;
    logic               r_running, n_running;
    logic               r_step_pending, n_step_pending;
    logic [WAIT_W-1:0]  n_wait;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                     w_advance;
    logic [TIME_W-1:0]        w_elapsed;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-FRAC_W-1:0] w_quot;
    logic [TIME_W-1:0]        w_scaled;
    logic [MINF_W-1:0]        w_minimum;

    // Move the input beat on when the result register is free or being drained
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RESET;
            r_step_ms   <= STEP_RESET;
            r_limit_en  <= 1'b0;
            r_min_frame <= MINF_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SCALE:     r_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_STEP:      r_step_ms   <= i_cfg_data[STEP_W-1:0];
                CFG_LIMIT_EN:  r_limit_en  <= i_cfg_data[0];
                CFG_MIN_FRAME: r_min_frame <= i_cfg_data[MINF_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the command beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= t_mode'(s_axis_tuser);
            r_in_now  <= s_axis_tdata;
        end
    end

    // Real time since the last frame begin, scaled advance with half-up rounding
    assign w_elapsed = r_in_now - r_last_real;
    assign w_prod    = PROD_W'(w_elapsed) * PROD_W'(r_scale) + ROUND_HALF;
    assign w_quot    = w_prod[PROD_W-1:FRAC_W];
    assign w_scaled  = (w_quot[PROD_W-FRAC_W-1:TIME_W] != '0) ? '1 : w_quot[TIME_W-1:0];

    // Clamp the minimum frame length
    assign w_minimum = (r_min_frame > MINF_MAX) ? MINF_MAX : r_min_frame;

    // Apply the command to the time state
    always_comb begin
        n_frames       = r_frames;
        n_last_real    = r_last_real;
        n_real_delta   = r_real_delta;
        n_game_delta   = r_game_delta;
        n_game_time    = r_game_time;
        n_started      = r_started;
        n_running      = r_running;
        n_step_pending = r_step_pending;
        n_wait         = '0;
        unique case (r_in_mode)
            MODE_FRAME_BEGIN: begin
                n_frames     = r_frames + 1'b1;
                n_real_delta = w_elapsed;
                n_last_real  = r_in_now;
                if (r_running) begin
                    n_game_delta = w_scaled;
                    n_game_time  = r_game_time + w_scaled;
                end else if (r_step_pending) begin
                    n_game_delta   = TIME_W'(r_step_ms);
                    n_game_time    = r_game_time + TIME_W'(r_step_ms);
                    n_step_pending = 1'b0;
                end else begin
                    n_game_delta = '0;
                end
            end
            MODE_FRAME_END: begin
                if (r_limit_en && (w_elapsed < TIME_W'(w_minimum))) begin
                    n_wait = w_minimum - w_elapsed[WAIT_W-1:0];
                end
            end
            MODE_START: begin
                if (!r_started) begin
                    n_started = 1'b1;
                    n_running = 1'b1;
                end
            end
            MODE_STOP: begin
                if (r_started) begin
                    n_started   = 1'b0;
                    n_running   = 1'b0;
                    n_game_time = '0;
                end
            end
            MODE_PAUSE: begin
                if (r_started) n_running = 1'b0;
            end
            MODE_RESUME: begin
                if (r_started) n_running = 1'b1;
            end
            MODE_STEP: begin
                n_started      = 1'b1;
                n_running      = 1'b0;
                n_step_pending = 1'b1;
            end
            default: ;
        endcase
    end

    // Advance the time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames       <= '0;
            r_last_real    <= '0;
            r_real_delta   <= '0;
            r_game_delta   <= '0;
            r_game_time    <= '0;
            r_started      <= 1'b0;
            r_running      <= 1'b0;
            r_step_pending <= 1'b0;
        end else if (w_advance) begin
            r_frames       <= n_frames;
            r_last_real    <= n_last_real;
            r_real_delta   <= n_real_delta;
            r_game_delta   <= n_game_delta;
            r_game_time    <= n_game_time;
            r_started      <= n_started;
            r_running      <= n_running;
            r_step_pending <= n_step_pending;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OUT_TDATA_W'({n_wait, n_running, n_started, n_frames,
                                        n_last_real, n_game_time, n_real_delta,
                                        n_game_delta});
        end
    end

    // Frame count moves by one on a frame begin and never otherwise
    a_frames_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_mode == MODE_FRAME_BEGIN |=> r_frames == $past(r_frames) + 1'b1)
        else $error("frame count did not advance on frame begin");

    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && r_in_mode == MODE_FRAME_BEGIN) |=> $stable(r_frames))
        else $error("frame count changed without a frame begin");

    // Free running implies started
    a_run_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_started)
        else $error("running while not started");

    // A stop of a started game clears game time
    a_stop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_mode == MODE_STOP && r_started |=> r_game_time == '0)
        else $error("stop did not clear game time");

    // A nonzero wait only appears with limiting enabled
    a_wait_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[OUT_USED_W-1 -: WAIT_W] != '0 |-> r_limit_en)
        else $error("wait reported with limiting off");

endmodule

@@ tb/timebase_checker.sv @@
// Result checker for the scaled game timebase: tracks commands, predicts and compares beats.
`timescale 1ns / 100ps

module timebase_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel, as seen at the block's slave side
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic [sgt_pkg::TIME_W-1:0]      i_cmd_now,
    input  logic [sgt_pkg::MODE_W-1:0]      i_cmd_mode,
    // result channel, as seen at the block's master side
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [sgt_pkg::OUT_TDATA_W-1:0] i_res_data,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sgt_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [sgt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sgt_pkg::*;

    // Members run from the top bit of the result beat down, so a cast of the
    // used bits lines up with the port layout.
    typedef struct packed {
        logic [WAIT_W-1:0] wait_ms;
        logic              running;
        logic              started;
        logic [TIME_W-1:0] frames;
        logic [TIME_W-1:0] real_stamp;
        logic [TIME_W-1:0] game_time;
        logic [TIME_W-1:0] real_delta;
        logic [TIME_W-1:0] game_delta;
    } t_timebase_result;

    // Register copy
    logic [SCALE_W-1:0] scale_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               limit_reg;
    logic [MINF_W-1:0]  min_frame_reg;

    // Timebase state
    logic [TIME_W-1:0]  frames_seen;
    logic [TIME_W-1:0]  last_frame_ms;
    logic [TIME_W-1:0]  real_delta_ms;
    logic [TIME_W-1:0]  game_delta_ms;
    logic [TIME_W-1:0]  game_time_ms;
    logic               started;
    logic               running;
    logic               step_pending;

    t_timebase_result   expected_results[$];
    int                 fail_total = 0;

    // Real delta times the Q8.8 scale, rounded half up, saturated to 32 bits
    function automatic logic [TIME_W-1:0] scaled_advance(input logic [TIME_W-1:0] delta);
        logic [PROD_W:0] product;
        product = {1'b0, delta} * {{(PROD_W - SCALE_W + 1){1'b0}}, scale_reg}
                  + (PROD_W + 1)'(128);
        product = product >> FRAC_W;
        if (product[PROD_W:TIME_W] != '0)
            return '1;
        return product[TIME_W-1:0];
    endfunction

    // Wait still needed at end of frame
    function automatic logic [WAIT_W-1:0] frame_wait(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] minimum;
        if (!limit_reg)
            return '0;
        minimum = (min_frame_reg > MINF_MAX) ? TIME_W'(MINF_MAX) : TIME_W'(min_frame_reg);
        elapsed = now - last_frame_ms;
        if (elapsed < minimum)
            return WAIT_W'(minimum - elapsed);
        return '0;
    endfunction

    // Apply one command to the state and form the beat it should produce
    task automatic apply_command(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now,
                                 output t_timebase_result res);
        logic [WAIT_W-1:0] wait_val;
        wait_val = '0;
        case (mode)
            MODE_FRAME_BEGIN: begin
                frames_seen   = frames_seen + 1'b1;
                real_delta_ms = now - last_frame_ms;
                last_frame_ms = now;
                if (running) begin
                    game_delta_ms = scaled_advance(real_delta_ms);
                    game_time_ms  = game_time_ms + game_delta_ms;
                end else if (step_pending) begin
                    game_delta_ms = TIME_W'(step_reg);
                    game_time_ms  = game_time_ms + game_delta_ms;
                    step_pending  = 1'b0;
                end else begin
                    game_delta_ms = '0;
                end
            end
            MODE_FRAME_END: wait_val = frame_wait(now);
            MODE_START: begin
                if (!started) begin
                    started = 1'b1;
                    running = 1'b1;
                end
            end
            MODE_STOP: begin
                if (started) begin
                    started      = 1'b0;
                    running      = 1'b0;
                    game_time_ms = '0;
                end
            end
            MODE_PAUSE: begin
                if (started && running)
                    running = 1'b0;
            end
            MODE_RESUME: begin
                if (started && !running)
                    running = 1'b1;
            end
            MODE_STEP: begin
                started      = 1'b1;
                running      = 1'b0;
                step_pending = 1'b1;
            end
            default: ;
        endcase
        res.game_delta = game_delta_ms;
        res.real_delta = real_delta_ms;
        res.game_time  = game_time_ms;
        res.real_stamp = last_frame_ms;
        res.frames     = frames_seen;
        res.started    = started;
        res.running    = running;
        res.wait_ms    = wait_val;
    endtask

    function automatic void check_field(input string name, input logic [TIME_W-1:0] exp_val,
                                        input logic [TIME_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_timebase_result predicted;
        t_timebase_result observed;
        if (!i_rst_n) begin
            scale_reg     = SCALE_RESET;
            step_reg      = STEP_RESET;
            limit_reg     = 1'b0;
            min_frame_reg = MINF_RESET;
            frames_seen   = '0;
            last_frame_ms = '0;
            real_delta_ms = '0;
            game_delta_ms = '0;
            game_time_ms  = '0;
            started       = 1'b0;
            running       = 1'b0;
            step_pending  = 1'b0;
            expected_results.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SCALE:     scale_reg     = i_cfg_data[SCALE_W-1:0];
                    CFG_STEP:      step_reg      = i_cfg_data[STEP_W-1:0];
                    CFG_LIMIT_EN:  limit_reg     = i_cfg_data[0];
                    CFG_MIN_FRAME: min_frame_reg = i_cfg_data[MINF_W-1:0];
                    default: ;
                endcase
            end
            // Predict the beat for each accepted command
            if (i_cmd_valid && i_cmd_ready) begin
                apply_command(i_cmd_mode, i_cmd_now, predicted);
                expected_results.push_back(predicted);
            end
            // Compare each accepted result beat with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                observed = t_timebase_result'(i_res_data[OUT_USED_W-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_total++;
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("game_delta_ms", predicted.game_delta, observed.game_delta);
                    check_field("real_delta_ms", predicted.real_delta, observed.real_delta);
                    check_field("game_time_ms", predicted.game_time, observed.game_time);
                    check_field("last_real_ms", predicted.real_stamp, observed.real_stamp);
                    check_field("frames", predicted.frames, observed.frames);
                    check_field("is_started", TIME_W'(predicted.started),
                                TIME_W'(observed.started));
                    check_field("is_running", TIME_W'(predicted.running),
                                TIME_W'(observed.running));
                    check_field("wait_ms", TIME_W'(predicted.wait_ms),
                                TIME_W'(observed.wait_ms));
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/testbench.sv @@
// Top of the scaled game timebase testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import sgt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 280;
    localparam int PHASE_COUNT    = 7;
    // Mode code with no command behind it
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [TIME_W-1:0]      s_axis_tdata   = '0;  // [31:0] now_ms
    logic [MODE_W-1:0]      s_axis_tuser   = '0;  // [2:0] mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // [31:0] game_delta_ms, [63:32] real_delta_ms, [95:64] game_time_ms,
    // [127:96] last_real_ms, [159:128] frames, [160] is_started,
    // [161] is_running, [171:162] wait_ms, [175:172] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;

    int                     fail_count;
    int                     pending_count;
    logic                   idle_on        = 1'b0;
    int                     stall_left     = 0;
    int                     idle_cycles    = 0;
    logic [TIME_W-1:0]      timer_ms       = '0;

    always #4 i_clk = ~i_clk;

    scaled_game_timebase_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    timebase_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_now    (s_axis_tdata),
        .i_cmd_mode   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Stall the result side in short random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // End the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one command beat and hold it until accepted
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= now;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Mostly well-formed frames on a steadily advancing timer, some noise
    task automatic send_random_cmd();
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] now;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            mode = MODE_W'($urandom_range(0, 7));
            now  = $urandom;
        end else begin
            if ($urandom_range(0, 49) == 0)
                timer_ms = timer_ms + $urandom;
            else
                timer_ms = timer_ms + $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                mode = MODE_FRAME_BEGIN;
            else if (pick < 70)
                mode = MODE_FRAME_END;
            else
                mode = MODE_W'($urandom_range(MODE_START, MODE_STEP));
            now = timer_ms;
        end
        send_cmd(mode, now);
    endtask

    // Drain the block, then rewrite all four registers
    task automatic apply_settings(input logic [SCALE_W-1:0] scale, input logic [STEP_W-1:0] step,
                                  input logic limit_en, input logic [MINF_W-1:0] min_frame);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SCALE;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_addr <= CFG_STEP;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_addr <= CFG_LIMIT_EN;
        i_cfg_data <= CFG_DATA_W'(limit_en);
        @(posedge i_clk);
        i_cfg_addr <= CFG_MIN_FRAME;
        i_cfg_data <= CFG_DATA_W'(min_frame);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on <= 1'b1;

        // Run-flag handling and frame accounting under the reset registers
        send_cmd(MODE_PAUSE, 32'd0);              // pause before start
        send_cmd(MODE_RESUME, 32'd0);             // resume before start
        send_cmd(MODE_STOP, 32'd0);               // stop while stopped
        send_cmd(MODE_FRAME_BEGIN, 32'd5);        // stopped, no step: no advance
        send_cmd(MODE_SPARE, 32'hFFFF_FFFF);      // unused mode
        send_cmd(MODE_START, 32'd10);
        send_cmd(MODE_START, 32'd11);             // start while started
        send_cmd(MODE_FRAME_BEGIN, 32'd21);
        send_cmd(MODE_FRAME_END, 32'd25);         // limiting off
        send_cmd(MODE_PAUSE, 32'd30);
        send_cmd(MODE_PAUSE, 32'd31);             // pause while paused
        send_cmd(MODE_FRAME_BEGIN, 32'd40);       // paused, nothing pending
        send_cmd(MODE_STEP, 32'd45);
        send_cmd(MODE_FRAME_BEGIN, 32'd56);       // single step taken
        send_cmd(MODE_FRAME_BEGIN, 32'd70);       // step already consumed
        send_cmd(MODE_RESUME, 32'd75);
        send_cmd(MODE_RESUME, 32'd76);            // resume while running
        send_cmd(MODE_FRAME_BEGIN, 32'hFFFF_FFFF);
        send_cmd(MODE_FRAME_BEGIN, 32'h0000_0010); // timer wraps
        send_cmd(MODE_STEP, 32'h0000_0020);       // step while running
        send_cmd(MODE_STOP, 32'h0000_0030);       // keeps the pending step
        send_cmd(MODE_STEP, 32'h0000_0040);       // step from stopped
        send_cmd(MODE_FRAME_BEGIN, 32'h8000_0000);
        send_cmd(MODE_FRAME_END, 32'h8000_0000);

        // Random phases across register settings, extremes first
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: apply_settings(16'd0, 16'd0, 1'b1, 10'd0);
                1: apply_settings(16'hFFFF, 16'hFFFF, 1'b1, MINF_MAX);
                2: apply_settings(SCALE_RESET, STEP_RESET, 1'b1, 10'h3FF);
                3: apply_settings(16'd128, 16'($urandom), 1'b1, 10'd1);
                4: apply_settings(16'($urandom), 16'($urandom), 1'b0,
                                  10'($urandom_range(1, 1000)));
                5: apply_settings(16'($urandom), 16'($urandom), 1'b1, 10'($urandom));
                default: begin
                    apply_settings(16'd384, STEP_RESET, 1'b1, 10'd33);
                    idle_on <= 1'b0;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_cmd();
        end

        // Drain and give the verdict
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
